// ===== src/decimal_mhz_to_hz_parser_defines.svh =====
// ----------------------------------------------------------------------------
// decimal mhz to hz parser assertion macros
// shared property forms for the parser block, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_MHZ_TO_HZ_PARSER_DEFINES_SVH
`define DECIMAL_MHZ_TO_HZ_PARSER_DEFINES_SVH

// condition implies consequence in the same cycle
`define DMHZ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define DMHZ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dmhz_pkg.sv =====
// ----------------------------------------------------------------------------
// dmhz_pkg
// constants, types and helpers of the decimal mhz to hz parser
// ----------------------------------------------------------------------------
`default_nettype none

package dmhz_pkg;

   // digit limits of the two parts of the number
   localparam int WHOLE_DIGITS    = 4;
   localparam int FRACTION_DIGITS = 6;

   // the fraction is always scaled to six decimal places (one hz)
   localparam int HZ_DIGITS = 6;

   localparam int CHAR_W   = 8;
   localparam int FREQ_W   = 34;
   localparam int WHOLE_W  = $clog2(10 ** WHOLE_DIGITS);
   localparam int FRAC_W   = $clog2(10 ** FRACTION_DIGITS);
   localparam int SCALED_W = $clog2(10 ** HZ_DIGITS);
   localparam int WCNT_W   = $clog2(WHOLE_DIGITS + 1);
   localparam int FCNT_W   = $clog2(FRACTION_DIGITS + 1);

   localparam logic [FREQ_W-1:0] HZ_PER_MHZ = FREQ_W'(10 ** HZ_DIGITS);

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // response status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // closed number handed from the parser to the scaling stages
   typedef struct packed {
      logic                valid;
      logic                bad;
      logic [WHOLE_W-1:0]  whole;
      logic [FRAC_W-1:0]   frac;
      logic [FCNT_W-1:0]   fcount;
   } snap_type;

   // 10 ** (HZ_DIGITS - count): weight that lines the fraction up on hz
   function automatic logic [SCALED_W-1:0] frac_scale(input logic [FCNT_W-1:0] count);
      logic [SCALED_W-1:0] weight;
      weight = SCALED_W'(1);
      for (int i = 0; i < HZ_DIGITS; i++) begin
         if (i >= int'(count)) begin
            weight = SCALED_W'(weight * SCALED_W'(10));
         end
      end
      return weight;
   endfunction

endpackage

`default_nettype wire

// ===== src/dmhz_if.sv =====
// ----------------------------------------------------------------------------
// dmhz channel interfaces
// valid/ready channels for characters in and frequency words out
// ----------------------------------------------------------------------------
`default_nettype none

interface dmhz_req_if;
   logic                          valid;
   logic                          ready;
   logic [dmhz_pkg::CHAR_W-1:0]   char_in;
   logic                          is_last;

   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface dmhz_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dmhz_pkg::FREQ_W-1:0]   freq_hz;
   logic                          status;

   modport source (output valid, output freq_hz, output status, input ready);
   modport sink   (input valid, input freq_hz, input status, output ready);
endinterface

`default_nettype wire

// ===== src/dmhz_parse.sv =====
// ----------------------------------------------------------------------------
// dmhz_parse
// character scanner: tracks phase, point and digit accumulators, closes a number
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_mhz_to_hz_parser_defines.svh"

module dmhz_parse (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire logic [dmhz_pkg::CHAR_W-1:0]  char_in,
   input  wire logic                         is_last,
   output dmhz_pkg::snap_type                snap
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_NUM,
      PH_TRAIL
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic                             point_ff, point_in;
   logic                             err_ff, err_in;
   logic [dmhz_pkg::WHOLE_W-1:0]     whole_ff, whole_in;
   logic [dmhz_pkg::WCNT_W-1:0]      wcount_ff, wcount_in;
   logic [dmhz_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [dmhz_pkg::FCNT_W-1:0]      fcount_ff, fcount_in;
   dmhz_pkg::snap_type               snap_ff;
   logic [3:0]                       digit;

   assign digit = 4'(char_in - dmhz_pkg::CHAR_ZERO);

   always_comb begin
      phase_in  = phase_ff;
      point_in  = point_ff;
      err_in    = err_ff;
      whole_in  = whole_ff;
      wcount_in = wcount_ff;
      frac_in   = frac_ff;
      fcount_in = fcount_ff;
      if (in_valid && !err_ff && char_in != dmhz_pkg::CHAR_NUL) begin
         if (char_in == dmhz_pkg::CHAR_SPACE) begin
            if (phase_ff == PH_NUM) begin
               phase_in = PH_TRAIL;
            end
         end else if (phase_ff == PH_TRAIL) begin
            err_in = 1'b1;
         end else if (char_in == dmhz_pkg::CHAR_POINT) begin
            if (point_ff) begin
               err_in = 1'b1;
            end else begin
               point_in = 1'b1;
               phase_in = PH_NUM;
            end
         end else if (!(char_in inside {[dmhz_pkg::CHAR_ZERO:dmhz_pkg::CHAR_NINE]})) begin
            err_in = 1'b1;
         end else begin
            phase_in = PH_NUM;
            if (!point_ff) begin
               if (wcount_ff >= dmhz_pkg::WCNT_W'(dmhz_pkg::WHOLE_DIGITS)) begin
                  err_in = 1'b1;
               end else begin
                  whole_in  = dmhz_pkg::WHOLE_W'(whole_ff * dmhz_pkg::WHOLE_W'(10)
                              + dmhz_pkg::WHOLE_W'(digit));
                  wcount_in = dmhz_pkg::WCNT_W'(wcount_ff + 1'b1);
               end
            end else begin
               if (fcount_ff >= dmhz_pkg::FCNT_W'(dmhz_pkg::FRACTION_DIGITS)) begin
                  err_in = 1'b1;
               end else begin
                  frac_in   = dmhz_pkg::FRAC_W'(frac_ff * dmhz_pkg::FRAC_W'(10)
                              + dmhz_pkg::FRAC_W'(digit));
                  fcount_in = dmhz_pkg::FCNT_W'(fcount_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         point_ff      <= 1'b0;
         err_ff        <= 1'b0;
         whole_ff      <= '0;
         wcount_ff     <= '0;
         frac_ff       <= '0;
         fcount_ff     <= '0;
         snap_ff.valid <= 1'b0;
      end else if (enable) begin
         snap_ff.valid  <= in_valid && is_last;
         snap_ff.bad    <= err_in || (wcount_in == '0 && fcount_in == '0);
         snap_ff.whole  <= whole_in;
         snap_ff.frac   <= frac_in;
         snap_ff.fcount <= fcount_in;
         if (in_valid && is_last) begin
            // number closed: back to a clean start for the next string
            phase_ff  <= PH_LEAD;
            point_ff  <= 1'b0;
            err_ff    <= 1'b0;
            whole_ff  <= '0;
            wcount_ff <= '0;
            frac_ff   <= '0;
            fcount_ff <= '0;
         end else begin
            phase_ff  <= phase_in;
            point_ff  <= point_in;
            err_ff    <= err_in;
            whole_ff  <= whole_in;
            wcount_ff <= wcount_in;
            frac_ff   <= frac_in;
            fcount_ff <= fcount_in;
         end
      end
   end

   assign snap = snap_ff;

   `DMHZ_ASSERT_NEXT(a_last_closes, enable && in_valid && is_last, snap_ff.valid, "last char did not close a number")
   `DMHZ_ASSERT_NEXT(a_last_clears, enable && in_valid && is_last, phase_ff == PH_LEAD && wcount_ff == '0 && fcount_ff == '0 && !err_ff, "state not cleared after last char")
   `DMHZ_ASSERT_SAME(a_ok_in_range, snap_ff.valid && !snap_ff.bad, snap_ff.fcount <= dmhz_pkg::FCNT_W'(dmhz_pkg::FRACTION_DIGITS), "ok number with too many fraction digits")

endmodule

`default_nettype wire

// ===== src/decimal_mhz_to_hz_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_mhz_to_hz_parser
// ascii mhz frequency string in, one character a word, hz value out
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one character a word (char_in) with is_last on the final
//   one; char_in of zero is no character and only serves to close a string
//   rsp_ch gives one word per string: freq_hz in hz and status (0 ok,
//   1 malformed or empty), freq_hz zero on error
//   a new character is taken every cycle unless rsp_ch stalls; the pipeline
//   is input register, scanner, scaling products and output register, and
//   the response passes through them in that order on its way to rsp_ch
//   sustained rate, stall-free, is 1 character per cycle, set by the single
//   scanner step per character (one multiply-by-ten accumulate per part)
//   when the receiver stalls a response, the whole pipeline holds and
//   req_ch.ready drops in the same cycle; nothing is lost or repeated
//   reset clears the pipeline valids and scanner state; the block is ready
//   in the first cycle after reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_mhz_to_hz_parser_defines.svh"

module decimal_mhz_to_hz_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   dmhz_req_if.sink   req_ch,
   dmhz_rsp_if.source rsp_ch
);

   // pipeline advance: the output register is free or being drained
   logic                             enable;

   // input register
   logic                             in_valid_ff;
   logic [dmhz_pkg::CHAR_W-1:0]      char_ff;
   logic                             last_ff;

   // closed number from the scanner
   dmhz_pkg::snap_type               snap;

   // scaling stage: whole part in hz and fraction in hz
   logic                             prod_valid_ff;
   logic                             prod_bad_ff;
   logic [dmhz_pkg::FREQ_W-1:0]      whole_hz_ff, whole_hz_in;
   logic [dmhz_pkg::SCALED_W-1:0]    frac_hz_ff, frac_hz_in;

   // output register
   logic                             rsp_valid_ff;
   logic [dmhz_pkg::FREQ_W-1:0]      freq_ff, freq_in;
   logic                             status_ff;

   assign enable       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   // input register, loaded on every advance so bubbles flow through
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_ch.valid;
         char_ff     <= req_ch.char_in;
         last_ff     <= req_ch.is_last;
      end
   end

   // scanner keeps per-string state and closes a number on the last char
   dmhz_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (in_valid_ff),
      .char_in  (char_ff),
      .is_last  (last_ff),
      .snap     (snap)
   );

   // whole part times one million, fits the result width
   assign whole_hz_in = dmhz_pkg::FREQ_W'(dmhz_pkg::FREQ_W'(snap.whole) * dmhz_pkg::HZ_PER_MHZ);
   // fraction lined up on six decimal places
   assign frac_hz_in  = dmhz_pkg::SCALED_W'(dmhz_pkg::SCALED_W'(snap.frac)
                        * dmhz_pkg::frac_scale(snap.fcount));

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (enable) begin
         prod_valid_ff <= snap.valid;
         prod_bad_ff   <= snap.bad;
         whole_hz_ff   <= whole_hz_in;
         frac_hz_ff    <= frac_hz_in;
      end
   end

   // final sum, zero on error
   assign freq_in = prod_bad_ff ? '0
                    : dmhz_pkg::FREQ_W'(whole_hz_ff + dmhz_pkg::FREQ_W'(frac_hz_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= prod_valid_ff;
         freq_ff      <= freq_in;
         status_ff    <= prod_bad_ff ? dmhz_pkg::STATUS_ERR : dmhz_pkg::STATUS_OK;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.freq_hz = freq_ff;
   assign rsp_ch.status  = status_ff;

   `DMHZ_ASSERT_SAME(a_stall_blocks_req, rsp_valid_ff && !rsp_ch.ready, !req_ch.ready, "input taken while output stalled")
   `DMHZ_ASSERT_SAME(a_err_zero_freq, rsp_valid_ff && status_ff == dmhz_pkg::STATUS_ERR, freq_ff == '0, "error response with nonzero frequency")
   `DMHZ_ASSERT_NEXT(a_prod_to_rsp, enable && prod_valid_ff, rsp_valid_ff, "scaled number did not reach output")

endmodule

`default_nettype wire

// ===== tb/decimal_mhz_to_hz_parser_test.sv =====
// ----------------------------------------------------------------------------
// decimal_mhz_to_hz_parser_test
// feeds ascii mhz strings one character a word and checks every hz word
// against an in-bench parser; random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_mhz_to_hz_parser_test;

   timeunit 1ns;
   timeprecision 1ps;

   // scanner phase of the in-bench parser
   typedef enum logic [1:0] {
      SCAN_LEAD,
      SCAN_NUM,
      SCAN_TRAIL
   } scan_phase_type;

   // one expected response word
   typedef struct {
      logic [dmhz_pkg::FREQ_W-1:0] freq;
      logic                        status;
   } hz_word_type;

   typedef logic [dmhz_pkg::CHAR_W-1:0] text_type[$];

   // parses accepted characters and holds the hz words still to come
   class mhz_parse_tracker;
      scan_phase_type                phase;
      logic                          point_seen;
      logic [dmhz_pkg::WHOLE_W-1:0]  whole_value;
      logic [dmhz_pkg::WCNT_W-1:0]   whole_count;
      logic [dmhz_pkg::FRAC_W-1:0]   frac_value;
      logic [dmhz_pkg::FCNT_W-1:0]   frac_count;
      logic                          error_seen;
      hz_word_type                   hz_due[$];
      int                            mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         phase       = SCAN_LEAD;
         point_seen  = 1'b0;
         whole_value = '0;
         whole_count = '0;
         frac_value  = '0;
         frac_count  = '0;
         error_seen  = 1'b0;
      endfunction

      function int pending();
         return hz_due.size();
      endfunction

      function void scan(logic [dmhz_pkg::CHAR_W-1:0] c);
         logic [3:0] digit;
         digit = 4'(c - dmhz_pkg::CHAR_ZERO);
         if (error_seen || c == dmhz_pkg::CHAR_NUL) return;
         if (c == dmhz_pkg::CHAR_SPACE) begin
            if (phase == SCAN_NUM) phase = SCAN_TRAIL;
            return;
         end
         if (phase == SCAN_TRAIL) begin
            error_seen = 1'b1;
         end else if (c == dmhz_pkg::CHAR_POINT) begin
            if (point_seen) begin
               error_seen = 1'b1;
            end else begin
               point_seen = 1'b1;
               phase      = SCAN_NUM;
            end
         end else if (c < dmhz_pkg::CHAR_ZERO || c > dmhz_pkg::CHAR_NINE) begin
            error_seen = 1'b1;
         end else begin
            phase = SCAN_NUM;
            if (!point_seen) begin
               if (int'(whole_count) >= dmhz_pkg::WHOLE_DIGITS) begin
                  error_seen = 1'b1;
               end else begin
                  whole_value = dmhz_pkg::WHOLE_W'(whole_value * 10 + digit);
                  whole_count = whole_count + 1'b1;
               end
            end else begin
               if (int'(frac_count) >= dmhz_pkg::FRACTION_DIGITS) begin
                  error_seen = 1'b1;
               end else begin
                  frac_value = dmhz_pkg::FRAC_W'(frac_value * 10 + digit);
                  frac_count = frac_count + 1'b1;
               end
            end
         end
      endfunction

      // accepted character; a last one closes the string and owes one word
      function void note_char(logic [dmhz_pkg::CHAR_W-1:0] c, logic last);
         hz_word_type w;
         longint      weight;
         scan(c);
         if (!last) return;
         if (error_seen || (whole_count == 0 && frac_count == 0)) begin
            w.freq   = '0;
            w.status = dmhz_pkg::STATUS_ERR;
         end else begin
            weight = 1;
            for (int i = int'(frac_count); i < dmhz_pkg::HZ_DIGITS; i++) weight = weight * 10;
            w.freq   = dmhz_pkg::FREQ_W'(longint'(whole_value) * longint'(dmhz_pkg::HZ_PER_MHZ)
                                         + longint'(frac_value) * weight);
            w.status = dmhz_pkg::STATUS_OK;
         end
         hz_due.push_back(w);
         clear();
      endfunction

      function void check_word(logic [dmhz_pkg::FREQ_W-1:0] freq, logic status);
         hz_word_type w;
         if (hz_due.size() == 0) begin
            $display("%0t unexpected word: freq_hz %0d status %0d", $time, freq, status);
            mismatches++;
            return;
         end
         w = hz_due.pop_front();
         if (freq !== w.freq) begin
            $display("%0t freq_hz mismatch: expected %0d actual %0d", $time, w.freq, freq);
            mismatches++;
         end
         if (status !== w.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, w.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dmhz_req_if req_ch ();
   dmhz_rsp_if rsp_ch ();

   decimal_mhz_to_hz_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 100 mhz clock
   always #5 clock = ~clock;

   mhz_parse_tracker tracker;

   // no gaps on either side while set
   logic steady = 1'b0;
   // characters other than zero accepted so far
   int   chars_sent = 0;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [dmhz_pkg::CHAR_W-1:0] any_digit();
      return dmhz_pkg::CHAR_ZERO + dmhz_pkg::CHAR_W'($urandom_range(0, 9));
   endfunction

   // a number laid out as leading spaces, whole digits, point, fraction, trailing spaces
   function automatic text_type make_number(int lead, int n_whole, bit with_point,
                                            int n_frac, int trail);
      text_type t;
      t = {};
      repeat (lead) t.push_back(dmhz_pkg::CHAR_SPACE);
      repeat (n_whole) t.push_back(any_digit());
      if (with_point) begin
         t.push_back(dmhz_pkg::CHAR_POINT);
         repeat (n_frac) t.push_back(any_digit());
      end
      repeat (trail) t.push_back(dmhz_pkg::CHAR_SPACE);
      return t;
   endfunction

   // random string: mostly well formed, some broken, some pure noise
   function automatic text_type make_text();
      text_type t;
      int       kind;
      int       n_whole;
      int       n_frac;
      bit       with_point;
      kind       = $urandom_range(0, 99);
      n_whole    = $urandom_range(0, dmhz_pkg::WHOLE_DIGITS);
      n_frac     = $urandom_range(0, dmhz_pkg::FRACTION_DIGITS);
      with_point = (n_whole == 0) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
      t = make_number($urandom_range(0, 2), n_whole, with_point, n_frac,
                      $urandom_range(0, 2));
      if (kind >= 90) begin
         // noise of any byte value
         t = {};
         repeat ($urandom_range(1, 6)) t.push_back(dmhz_pkg::CHAR_W'($urandom_range(0, 255)));
      end else if (kind >= 70) begin
         case ($urandom_range(0, 4))
            0: t = make_number($urandom_range(0, 1), dmhz_pkg::WHOLE_DIGITS + 1, 1'b0, 0, 0);
            1: t = make_number(0, n_whole, 1'b1, dmhz_pkg::FRACTION_DIGITS + 1,
                               $urandom_range(0, 1));
            2: t.insert($urandom_range(0, t.size()), dmhz_pkg::CHAR_W'($urandom_range(0, 255)));
            3: t.insert($urandom_range(0, t.size()), dmhz_pkg::CHAR_POINT);
            default: begin
               t.push_back(dmhz_pkg::CHAR_SPACE);
               t.push_back(($urandom_range(0, 1) != 0) ? any_digit() : dmhz_pkg::CHAR_POINT);
            end
         endcase
      end
      // stray zero characters inside, and sometimes a zero to close
      if ($urandom_range(0, 7) == 0) t.insert($urandom_range(0, t.size()), dmhz_pkg::CHAR_NUL);
      if (t.size() == 0 || $urandom_range(0, 5) == 0) t.push_back(dmhz_pkg::CHAR_NUL);
      return t;
   endfunction

   // one character word; valid stays up across back-to-back words
   task automatic send_char(logic [dmhz_pkg::CHAR_W-1:0] c, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= c;
      req_ch.is_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_char(c, last);
      if (c != dmhz_pkg::CHAR_NUL) chars_sent++;
   endtask

   task automatic send_text(text_type t);
      foreach (t[i]) send_char(t[i], i == t.size() - 1);
   endtask

   // ascii literal, optionally closed by a zero character
   task automatic send_string(string s, bit nul_close);
      text_type t;
      t = {};
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      if (nul_close || t.size() == 0) t.push_back(dmhz_pkg::CHAR_NUL);
      send_text(t);
   endtask

   // response side: check accepted words, then stall at random
   initial begin : rsp_side
      int stall;
      stall        = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            tracker.check_word(rsp_ch.freq_hz, rsp_ch.status);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall = pick_gap();
            rsp_ch.ready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   initial begin : stimulus
      int n_strings;
      tracker        = new();
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.char_in = dmhz_pkg::CHAR_NUL;
      req_ch.is_last = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      send_string("9999.999999", 1'b0);  // largest value
      send_string("", 1'b1);             // empty string closed by a zero character
      send_string(" .5 ", 1'b0);         // fraction only, leading and trailing spaces
      send_string("1.2.", 1'b0);         // second point
      send_string("12345", 1'b0);        // too many whole digits
      send_string("1 2", 1'b0);          // digit after the number has ended
      send_string("x7", 1'b0);           // non-digit, rest ignored
      send_string(".", 1'b0);            // lone point
      send_string("  ", 1'b0);           // only spaces

      // random strings
      n_strings = 0;
      while (chars_sent < 1400) begin
         steady = ((n_strings % 40) >= 32);
         send_text(make_text());
         n_strings++;
         if (n_strings == 60) begin
            // sender holds off until every word is back
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (tracker.pending() > 0) @(posedge clock);
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // drain, then wait for the pipeline to empty
      while (tracker.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // timeout guard
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
